>>> rtl/core/rpf_pkg.sv
// Package for the request pattern filter: sizes, pattern constants and verdict codes.
`default_nettype none

package rpf_pkg;

  // Byte limit per request and derived counter width
  localparam int unsigned MaxRequestBytes = 4096;
  localparam int unsigned CntW            = $clog2(MaxRequestBytes + 1);

  // History depth in bytes (window is history plus the current byte)
  localparam int unsigned HistDepth = 20;
  localparam int unsigned HistW     = HistDepth * 8;
  localparam int unsigned WinW      = HistW + 8;

  // Pattern lengths in bytes
  localparam int unsigned LenUnion  = 12;
  localparam int unsigned LenOneEq  = 3;
  localparam int unsigned LenScript = 8;
  localparam int unsigned LenJs     = 11;
  localparam int unsigned LenDrop   = 10;
  localparam int unsigned LenVerify = 14;
  localparam int unsigned LenFprint = 21;

  // Patterns, first character in the top byte, last character in the bottom byte
  localparam logic [LenUnion*8-1:0]  PatUnion  = "UNION SELECT";
  localparam logic [LenOneEq*8-1:0]  PatOneEq  = "1=1";
  localparam logic [LenScript*8-1:0] PatScript = "<script>";
  localparam logic [LenJs*8-1:0]     PatJs     = "javascript:";
  localparam logic [LenDrop*8-1:0]   PatDrop   = "DROP TABLE";
  localparam logic [LenVerify*8-1:0] PatVerify = "/api/qr/verify";
  localparam logic [LenFprint*8-1:0] PatFprint = "X-Device-Fingerprint:";

  // Verdict codes
  typedef enum logic [1:0] {
    VerdictPass       = 2'd0,
    VerdictMalicious  = 2'd1,
    VerdictNoFprint   = 2'd2,
    VerdictVerified   = 2'd3
  } verdict_e;

endpackage

`default_nettype wire

>>> rtl/core/rpf_if.sv
// Stream interfaces of the request pattern filter: byte input and verdict output.
`default_nettype none

interface rpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] request_byte;
  logic       is_last;

  modport source (output valid, output request_byte, output is_last, input ready);
  modport sink   (input valid, input request_byte, input is_last, output ready);
endinterface

interface rpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

>>> rtl/core/request_pattern_filter.sv
// Top level of the request pattern filter: byte register, parallel match, verdict register.
// The byte marked last passes the input register, then its verdict is held in the verdict register.
// Throughput: one byte per cycle; the input register stalls only when a verdict
//   word waits in the output register and a second last byte is ready behind it.
// All seven patterns are compared in parallel against the 20-byte history and the new byte.
// Reset (rst_ni low, asynchronous) clears history, byte count, match flags and both valids.
`default_nettype none

module request_pattern_filter (
  input  wire        clk_i,
  input  wire        rst_ni,
  rpf_in_if.sink     req_i,
  rpf_out_if.source  res_o
);
  import rpf_pkg::*;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       advance;

  // Request state
  logic [HistW-1:0] hist_q, hist_d;
  logic [CntW-1:0]  taken_q, taken_d;
  logic             attack_q, attack_d;
  logic             endpoint_q, endpoint_d;
  logic             fprint_q, fprint_d;
  logic             ended_q, ended_d;

  // Output register
  logic     out_valid_q;
  verdict_e verdict_q, verdict_d;

  // Match logic
  logic [WinW-1:0] win;
  logic            ended_now;
  logic            take;
  logic            hit_attack, hit_endpoint, hit_fprint;
  logic            attack_all, endpoint_all, fprint_all;

  // A stage-1 word moves on unless it is a last byte facing a full, stalled output
  assign advance   = s1_valid_q & (~s1_last_q | ~out_valid_q | res_o.ready);
  assign req_i.ready = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_byte_q <= req_i.request_byte;
      s1_last_q <= req_i.is_last;
    end
  end

  // Window: newest byte in the bottom byte lane
  assign win       = {hist_q, s1_byte_q};
  assign ended_now = ended_q | (taken_q >= CntW'(MaxRequestBytes)) | (s1_byte_q == 8'd0);
  assign take      = ~ended_now;

  assign hit_attack = (win[LenUnion*8-1:0]  == PatUnion)  |
                      (win[LenOneEq*8-1:0]  == PatOneEq)  |
                      (win[LenScript*8-1:0] == PatScript) |
                      (win[LenJs*8-1:0]     == PatJs)     |
                      (win[LenDrop*8-1:0]   == PatDrop);
  assign hit_endpoint = (win[LenVerify*8-1:0] == PatVerify);
  assign hit_fprint   = (win[LenFprint*8-1:0] == PatFprint);

  assign attack_all   = attack_q   | (take & hit_attack);
  assign endpoint_all = endpoint_q | (take & hit_endpoint);
  assign fprint_all   = fprint_q   | (take & hit_fprint);

  // Next request state; a last byte returns everything to the reset values
  always_comb begin
    hist_d     = hist_q;
    taken_d    = taken_q;
    attack_d   = attack_all;
    endpoint_d = endpoint_all;
    fprint_d   = fprint_all;
    ended_d    = ended_now;
    if (take) begin
      hist_d  = {hist_q[HistW-9:0], s1_byte_q};
      taken_d = taken_q + CntW'(1);
    end
    if (s1_last_q) begin
      hist_d     = '0;
      taken_d    = '0;
      attack_d   = 1'b0;
      endpoint_d = 1'b0;
      fprint_d   = 1'b0;
      ended_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      taken_q    <= '0;
      attack_q   <= 1'b0;
      endpoint_q <= 1'b0;
      fprint_q   <= 1'b0;
      ended_q    <= 1'b0;
    end else if (advance) begin
      hist_q     <= hist_d;
      taken_q    <= taken_d;
      attack_q   <= attack_d;
      endpoint_q <= endpoint_d;
      fprint_q   <= fprint_d;
      ended_q    <= ended_d;
    end
  end

  // Verdict priority: attack, then endpoint with or without fingerprint
  always_comb begin
    if (attack_all) begin
      verdict_d = VerdictMalicious;
    end else if (endpoint_all) begin
      verdict_d = fprint_all ? VerdictVerified : VerdictNoFprint;
    end else begin
      verdict_d = VerdictPass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.verdict = verdict_q;

  // Checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> (taken_q == '0) && !attack_q && !endpoint_q
                               && !fprint_q && !ended_q)
    else $error("request state not cleared after last byte");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= CntW'(MaxRequestBytes))
    else $error("byte count beyond limit");

  a_end_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ended_q) |-> $past(advance && s1_last_q))
    else $error("scan end dropped within a request");

  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(advance && s1_last_q))
    else $error("verdict word without a last byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !(advance && s1_last_q))
    else $error("pending verdict word overwritten");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for request_pattern_filter: byte stream stimulus, verdict prediction and checking.
`timescale 1ns / 1ps

module tb;
  import rpf_pkg::*;

  // Matching limits and pattern table indexes
  localparam int unsigned ByteLimit   = 4096;
  localparam int unsigned HistBytes   = 20;
  localparam int          NumPatterns = 7;
  localparam int          NumAttacks  = 5;
  localparam int          EndpointPat = 5;
  localparam int          FprintPat   = 6;
  localparam int          RandomBytes = 1400;
  localparam int          MinRandReqs = 40;
  localparam int          LongHold    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpf_in_if  req_if ();
  rpf_out_if res_if ();

  request_pattern_filter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic string pattern_of(int k);
    case (k)
      0:       return "UNION SELECT";
      1:       return "1=1";
      2:       return "<script>";
      3:       return "javascript:";
      4:       return "DROP TABLE";
      5:       return "/api/qr/verify";
      default: return "X-Device-Fingerprint:";
    endcase
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Tracks one request at a time and holds the verdicts still owed by the block
  class verdict_scoreboard;
    logic [8*HistBytes-1:0] recent;
    int unsigned            taken;
    bit                     attack_hit;
    bit                     endpoint_hit;
    bit                     fprint_hit;
    bit                     scan_done;
    verdict_e               owed_verdicts[$];
    int unsigned            errors;
    int unsigned            words_in;
    int unsigned            verdict_tally[4];

    function new();
      clear_request();
      errors   = 0;
      words_in = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
    endfunction

    function void clear_request();
      recent       = '0;
      taken        = 0;
      attack_hit   = 1'b0;
      endpoint_hit = 1'b0;
      fprint_hit   = 1'b0;
      scan_done    = 1'b0;
    endfunction

    // Accepted input word: update history and match flags, owe a verdict on last
    function void take_byte(logic [7:0] b, logic last);
      logic [8*HistBytes+7:0] win;
      string                  s;
      bit                     hit;
      words_in++;
      if (!scan_done && taken >= ByteLimit) scan_done = 1'b1;
      if (!scan_done && b == 8'h00) scan_done = 1'b1;
      if (!scan_done) begin
        win = {recent, b};
        for (int k = 0; k < NumPatterns; k++) begin
          s   = pattern_of(k);
          hit = 1'b1;
          for (int i = 0; i < s.len(); i++) begin
            if (win[8*(s.len()-1-i) +: 8] != 8'(s[i])) hit = 1'b0;
          end
          if (hit) begin
            if (k < NumAttacks) attack_hit = 1'b1;
            else if (k == EndpointPat) endpoint_hit = 1'b1;
            else if (k == FprintPat) fprint_hit = 1'b1;
          end
        end
        recent = win[8*HistBytes-1:0];
        taken++;
      end
      if (last) begin
        if (attack_hit) owed_verdicts.push_back(VerdictMalicious);
        else if (endpoint_hit)
          owed_verdicts.push_back(fprint_hit ? VerdictVerified : VerdictNoFprint);
        else owed_verdicts.push_back(VerdictPass);
        clear_request();
      end
    endfunction

    function void check_verdict(verdict_e got);
      verdict_e want;
      if (owed_verdicts.size() == 0) begin
        $error("verdict %0d arrived with none expected", got);
        errors++;
        return;
      end
      want = owed_verdicts.pop_front();
      verdict_tally[want]++;
      if (got !== want) begin
        $error("verdict mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction
  endclass

  verdict_scoreboard sb = new();

  logic [7:0] req_buf[$];
  bit         send_calm;
  bit         recv_calm;
  bit         hold_request;

  // Request building
  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) req_buf.push_back(8'(s[i]));
  endfunction

  function automatic void put_fill(int n);
    for (int i = 0; i < n; i++) req_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
  endfunction

  // One random fragment: pattern, cut or altered pattern, text, raw bytes or zero
  function automatic void add_piece();
    string s;
    int    r;
    int    n;
    int    i;
    r = $urandom_range(0, 99);
    s = pattern_of($urandom_range(0, NumPatterns - 1));
    if (r < 30) begin
      put(s);
    end else if (r < 45) begin
      put(s.substr(0, $urandom_range(0, s.len() - 2)));
    end else if (r < 55) begin
      i = $urandom_range(0, s.len() - 1);
      s[i] = ($urandom_range(0, 1) != 0) ? (s[i] ^ 8'h20) : 8'($urandom_range(1, 255));
      put(s);
    end else if (r < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) req_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end else if (r < 95) begin
      n = $urandom_range(1, 4);
      repeat (n) req_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      req_buf.push_back(8'h00);
    end
  endfunction

  // Offer one word after an optional gap, return once it is taken
  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.request_byte <= b;
    req_if.is_last      <= last;
    do @(posedge clk_i); while (!req_if.ready);
    sb.take_byte(b, last);
  endtask

  task automatic send_request();
    for (int i = 0; i < req_buf.size(); i++) push_byte(req_buf[i], i == req_buf.size() - 1);
    req_buf.delete();
  endtask

  // Verdict receiver: random stalls, calm stretches and one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    recv_calm  = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_verdict(verdict_e'(res_if.verdict));
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(recv_calm);
      end
    end
  end

  // Stimulus
  initial begin
    int rand_bytes;
    int rand_reqs;
    int n;
    rand_bytes   = 0;
    rand_reqs    = 0;
    send_calm    = 1'b0;
    hold_request = 1'b0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.request_byte <= 8'h00;
    req_if.is_last      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain text, every pattern, verdict priority, zero byte, case,
    // byte extremes, split across requests, byte limit at and past the edge
    put("GET / HTTP/1.1"); send_request();
    put("a UNION SELECT b"); send_request();
    put("x=1=1"); send_request();
    put("<script>"); send_request();
    put("javascript:"); send_request();
    put("DROP TABLE"); send_request();
    put("/api/qr/verify"); send_request();
    put("POST /api/qr/verify\nX-Device-Fingerprint: 1f"); send_request();
    put("X-Device-Fingerprint: zz"); send_request();
    put("X-Device-Fingerprint:/api/qr/verify"); send_request();
    put("/api/qr/verify 1=1 X-Device-Fingerprint:"); send_request();
    put("ab"); req_buf.push_back(8'h00); put("DROP TABLE"); send_request();
    put("union select"); send_request();
    req_buf.push_back(8'h00); send_request();
    req_buf.push_back(8'hff); req_buf.push_back(8'h80); req_buf.push_back(8'h01);
    send_request();
    put("UNION SEL"); send_request();
    put("ECT"); send_request();
    send_calm = 1'b1;
    put_fill(ByteLimit - 12); put("UNION SELECT"); send_request();
    put_fill(ByteLimit - 11); put("UNION SELECT"); send_request();
    send_calm = 1'b0;

    // Random requests: mostly pattern fragments, some pure noise
    while (rand_bytes < RandomBytes || rand_reqs < MinRandReqs) begin
      send_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 30);
        repeat (n) req_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) add_piece();
      end
      rand_bytes += req_buf.size();
      rand_reqs++;
      // receiver holds off while short requests keep coming
      if (rand_reqs == 15) hold_request = 1'b1;
      // sender waits for the block to drain
      if (rand_reqs == 30) begin
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_request();
    end
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d words in, %0d random, over %0d random requests", sb.words_in,
             rand_bytes, rand_reqs);
    $display("tb: verdicts pass %0d, malicious %0d, no fingerprint %0d, verified %0d",
             sb.verdict_tally[VerdictPass], sb.verdict_tally[VerdictMalicious],
             sb.verdict_tally[VerdictNoFprint], sb.verdict_tally[VerdictVerified]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> request_pattern_filter.f
rtl/core/rpf_pkg.sv
rtl/core/rpf_if.sv
rtl/core/request_pattern_filter.sv
dv/tb.sv
